// ===== rtl/graph_segment_merge_core_assert.svh =====
// assertion macros for the graph segment merge core checker
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef GRAPH_SEGMENT_MERGE_CORE_ASSERT_SVH
`define GRAPH_SEGMENT_MERGE_CORE_ASSERT_SVH

// condition that must hold at every clock edge out of reset
`define GSM_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// consequent checked in the same cycle as the antecedent
`define GSM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define GSM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/gsm_pkg.sv =====
// shared constants and types of the graph segment merge core
// no dependencies
`timescale 1ns / 1ps

package gsm_pkg;

  // forest size and weight precision
  localparam int VERTICES    = 65536;
  localparam int WEIGHT_BITS = 16;

  // fixed field widths of the item and register formats
  localparam int VIDX_W     = 16;
  localparam int WEIGHT_IN_W = 16;
  localparam int CNT_W      = 17;
  localparam int K_W        = 24;
  localparam int S_TDATA_W  = 48;
  localparam int M_TDATA_W  = 24;

  // derived widths
  localparam int ADDR_W = $clog2(VERTICES);
  localparam int SIZE_W = $clog2(VERTICES + 1);
  localparam int WUSE_W = (WEIGHT_BITS < WEIGHT_IN_W) ? WEIGHT_BITS : WEIGHT_IN_W;

  // register reset values
  localparam int RESET_K      = 300;
  localparam int RESET_VIU    = 65536;
  localparam int RESET_ACTIVE = (RESET_VIU > VERTICES) ? VERTICES : RESET_VIU;

  // configuration register indexes
  typedef enum logic {
    REG_THRESHOLD_K     = 1'b0,
    REG_VERTICES_IN_USE = 1'b1
  } cfg_reg_e;

  // one forest entry as stored in memory
  typedef struct packed {
    logic [WUSE_W-1:0] imax;
    logic [SIZE_W-1:0] size;
    logic [ADDR_W-1:0] parent;
  } word_t;

  localparam int WORD_W = $bits(word_t);

  // limit test request and response
  typedef struct packed {
    logic              vld;
    logic [WUSE_W-1:0] weight;
    logic [WUSE_W-1:0] imax;
    logic [SIZE_W-1:0] size;
  } lim_req_t;

  typedef struct packed {
    logic vld;
    logic ok;
  } lim_rsp_t;

endpackage

// ===== rtl/gsm_ram.sv =====
// generic simple dual port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module gsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/gsm_limit_test.sv =====
// two stage merge limit test: (w - imax) * size <= k
// depends on gsm_pkg
`timescale 1ns / 1ps

module gsm_limit_test (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  gsm_pkg::lim_req_t   req_i,
  input  logic [gsm_pkg::K_W-1:0] k_i,
  output gsm_pkg::lim_rsp_t   rsp_o
);
  import gsm_pkg::*;

  localparam int PROD_W = WUSE_W + SIZE_W;
  localparam int CMP_W  = (PROD_W > K_W) ? PROD_W : K_W;

  logic [WUSE_W-1:0] diff;
  logic [PROD_W-1:0] prod_d, prod_q;
  logic              vld1_q, vld2_q, ok_q, ok_d;

  // w <= imax passes for any k
  assign diff   = (req_i.weight > req_i.imax) ? (req_i.weight - req_i.imax) : '0;
  assign prod_d = PROD_W'(diff) * PROD_W'(req_i.size);
  assign ok_d   = CMP_W'(prod_q) <= CMP_W'(k_i);

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    ok_q   <= ok_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
    end else begin
      vld1_q <= req_i.vld;
      vld2_q <= vld1_q;
    end
  end

  assign rsp_o.vld = vld2_q;
  assign rsp_o.ok  = ok_q;

endmodule

// ===== rtl/graph_segment_merge_core.sv =====
// top level of the graph segment merge core: forest memory, sequencer, limit test
// depends on gsm_pkg, gsm_ram, gsm_limit_test
`timescale 1ns / 1ps

// Merge stage of graph based image segmentation. Edges come in on the slave
// stream sorted by ascending weight; each one yields exactly one result
// transfer on the master stream. The union-find forest (parent, set size and
// largest internal weight per vertex) lives in one memory of VERTICES words
// with a registered read. After reset the block runs a clearing pass over all
// VERTICES words with s_axis_tready low; a clear command is accepted, runs the
// same pass and then loads its result. An edge is accepted, then walks from
// each endpoint to its root, one node visited per step; when the roots differ
// the two limit tests run on the shared multiplier, both roots are written
// when the sets are joined, and the result is loaded. A result waits in
// ST_REPLY for as long as the output register is stalled. The walk is bounded
// by the single memory read port, one read per cycle; each step also relinks
// the previous node to its grandparent (path splitting), so trees stay
// shallow. Edges with an endpoint at or past the active vertex count return
// merged and same_segment low and change nothing. Configuration writes are
// always taken and must only come while idle.
module graph_segment_merge_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // slave stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // first_vertex [15:0], second_vertex [31:16], edge_weight [47:32]
  input  logic [gsm_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // command [0]
  input  logic                          s_axis_tuser,
  // last_edge
  input  logic                          s_axis_tlast,
  // master stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // merged [0], same_segment [1], seg_left [18:2], zero [23:19]
  output logic [gsm_pkg::M_TDATA_W-1:0] m_axis_tdata,
  // done_res
  output logic                          m_axis_tlast,
  // configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic                          cfg_index_i,
  input  logic [gsm_pkg::K_W-1:0]       cfg_data_i
);
  import gsm_pkg::*;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FIND,
    ST_LIM_A,
    ST_LIM_B,
    ST_LIM_RA,
    ST_LIM_RB,
    ST_JOIN_A,
    ST_JOIN_B,
    ST_REPLY
  } state_e;

  // sequencer state
  state_e            state_d, state_q;
  logic [ADDR_W-1:0] clr_ctr_d, clr_ctr_q;
  logic              clr_reply_d, clr_reply_q;

  // captured edge
  logic [ADDR_W-1:0] b_d, b_q;
  logic [WUSE_W-1:0] w_d, w_q;
  logic              last_d, last_q;

  // root walk
  logic              phase_b_d, phase_b_q;
  logic              have_prev_d, have_prev_q;
  logic [ADDR_W-1:0] cur_d, cur_q;
  logic [ADDR_W-1:0] prev_d, prev_q;
  word_t             prev_word_d, prev_word_q;

  // roots found
  logic [ADDR_W-1:0] ra_d, ra_q, rb_d, rb_q;
  logic [SIZE_W-1:0] ra_size_d, ra_size_q, rb_size_d, rb_size_q;
  logic [WUSE_W-1:0] ra_imax_d, ra_imax_q, rb_imax_d, rb_imax_q;
  logic              ok_a_d, ok_a_q;

  // pending result and segment counter
  logic              merged_d, merged_q, same_d, same_q;
  logic [CNT_W-1:0]  seg_d, seg_q;

  // configuration registers
  logic [K_W-1:0]    k_d, k_q;
  logic [CNT_W-1:0]  viu_d, viu_q;
  logic [CNT_W-1:0]  active;

  // output register
  logic              out_valid_d, out_valid_q;
  logic              out_merged_d, out_merged_q, out_same_d, out_same_q;
  logic [CNT_W-1:0]  out_count_d, out_count_q;
  logic              out_last_d, out_last_q;

  // memory and limit unit interface
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  word_t             ram_wdata;
  logic [WORD_W-1:0] ram_rdata;
  word_t             rd_word;
  lim_req_t          lim_req;
  lim_rsp_t          lim_rsp;

  // input field views
  logic [VIDX_W-1:0] in_a, in_b;
  logic              in_accept;
  logic              in_range;

  assign in_a      = s_axis_tdata[VIDX_W-1:0];
  assign in_b      = s_axis_tdata[2*VIDX_W-1:VIDX_W];
  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign rd_word   = ram_rdata;

  // active vertex count saturates at the forest size
  assign active   = (32'(viu_q) > 32'(VERTICES)) ? CNT_W'(VERTICES) : viu_q;
  assign in_range = (CNT_W'(in_a) < active) && (CNT_W'(in_b) < active);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;

  // configuration writes
  always_comb begin
    k_d   = k_q;
    viu_d = viu_q;
    if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_THRESHOLD_K:     k_d   = cfg_data_i;
        REG_VERTICES_IN_USE: viu_d = cfg_data_i[CNT_W-1:0];
        default:             k_d   = k_q;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_d      = state_q;
    clr_ctr_d    = clr_ctr_q;
    clr_reply_d  = clr_reply_q;
    b_d          = b_q;
    w_d          = w_q;
    last_d       = last_q;
    phase_b_d    = phase_b_q;
    have_prev_d  = have_prev_q;
    cur_d        = cur_q;
    prev_d       = prev_q;
    prev_word_d  = prev_word_q;
    ra_d         = ra_q;
    rb_d         = rb_q;
    ra_size_d    = ra_size_q;
    rb_size_d    = rb_size_q;
    ra_imax_d    = ra_imax_q;
    rb_imax_d    = rb_imax_q;
    ok_a_d       = ok_a_q;
    merged_d     = merged_q;
    same_d       = same_q;
    seg_d        = seg_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_merged_d = out_merged_q;
    out_same_d   = out_same_q;
    out_count_d  = out_count_q;
    out_last_d   = out_last_q;

    ram_we    = 1'b0;
    ram_waddr = clr_ctr_q;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = cur_q;

    lim_req        = '0;
    lim_req.weight = w_q;
    lim_req.imax   = ra_imax_q;
    lim_req.size   = ra_size_q;

    unique case (state_q)
      ST_CLEAR: begin
        // every vertex back to a singleton root
        ram_we           = 1'b1;
        ram_waddr        = clr_ctr_q;
        ram_wdata.parent = clr_ctr_q;
        ram_wdata.size   = SIZE_W'(1);
        ram_wdata.imax   = '0;
        clr_ctr_d        = clr_ctr_q + ADDR_W'(1);
        if (clr_ctr_q == ADDR_W'(VERTICES - 1)) begin
          clr_ctr_d = '0;
          state_d   = clr_reply_q ? ST_REPLY : ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_accept) begin
          b_d         = ADDR_W'(in_b);
          w_d         = s_axis_tdata[2*VIDX_W +: WUSE_W];
          last_d      = s_axis_tlast;
          merged_d    = 1'b0;
          same_d      = 1'b0;
          phase_b_d   = 1'b0;
          have_prev_d = 1'b0;
          cur_d       = ADDR_W'(in_a);
          if (s_axis_tuser) begin
            clr_ctr_d   = '0;
            clr_reply_d = 1'b1;
            seg_d       = active;
            state_d     = ST_CLEAR;
          end else if (!in_range) begin
            state_d = ST_REPLY;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = ADDR_W'(in_a);
            state_d   = ST_FIND;
          end
        end
      end

      ST_FIND: begin
        if (rd_word.parent == cur_q) begin
          if (!phase_b_q) begin
            ra_d        = cur_q;
            ra_size_d   = rd_word.size;
            ra_imax_d   = rd_word.imax;
            phase_b_d   = 1'b1;
            have_prev_d = 1'b0;
            cur_d       = b_q;
            ram_re      = 1'b1;
            ram_raddr   = b_q;
          end else begin
            rb_d      = cur_q;
            rb_size_d = rd_word.size;
            rb_imax_d = rd_word.imax;
            if (cur_q == ra_q) begin
              same_d  = 1'b1;
              state_d = ST_REPLY;
            end else begin
              state_d = ST_LIM_A;
            end
          end
        end else begin
          // path splitting: previous node now points at its grandparent
          if (have_prev_q) begin
            ram_we           = 1'b1;
            ram_waddr        = prev_q;
            ram_wdata        = prev_word_q;
            ram_wdata.parent = rd_word.parent;
          end
          prev_d      = cur_q;
          prev_word_d = rd_word;
          have_prev_d = 1'b1;
          cur_d       = rd_word.parent;
          ram_re      = 1'b1;
          ram_raddr   = rd_word.parent;
        end
      end

      ST_LIM_A: begin
        lim_req.vld = 1'b1;
        state_d     = ST_LIM_B;
      end

      ST_LIM_B: begin
        lim_req.vld  = 1'b1;
        lim_req.imax = rb_imax_q;
        lim_req.size = rb_size_q;
        state_d      = ST_LIM_RA;
      end

      ST_LIM_RA: begin
        if (lim_rsp.vld) begin
          ok_a_d  = lim_rsp.ok;
          state_d = ST_LIM_RB;
        end
      end

      ST_LIM_RB: begin
        if (lim_rsp.vld) begin
          state_d = (ok_a_q && lim_rsp.ok) ? ST_JOIN_A : ST_REPLY;
        end
      end

      ST_JOIN_A: begin
        // surviving root takes the summed size and the edge weight
        ram_we           = 1'b1;
        ram_waddr        = ra_q;
        ram_wdata.parent = ra_q;
        ram_wdata.size   = SIZE_W'(ra_size_q + rb_size_q);
        ram_wdata.imax   = w_q;
        merged_d         = 1'b1;
        if (seg_q != '0) begin
          seg_d = seg_q - CNT_W'(1);
        end
        state_d = ST_JOIN_B;
      end

      ST_JOIN_B: begin
        ram_we           = 1'b1;
        ram_waddr        = rb_q;
        ram_wdata.parent = ra_q;
        ram_wdata.size   = rb_size_q;
        ram_wdata.imax   = rb_imax_q;
        state_d          = ST_REPLY;
      end

      ST_REPLY: begin
        // result waits here until the output register is free
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d  = 1'b1;
          out_merged_d = merged_q;
          out_same_d   = same_q;
          out_count_d  = seg_q;
          out_last_d   = last_q;
          clr_reply_d  = 1'b0;
          state_d      = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_ctr_q   <= '0;
      clr_reply_q <= 1'b0;
      phase_b_q   <= 1'b0;
      have_prev_q <= 1'b0;
      merged_q    <= 1'b0;
      same_q      <= 1'b0;
      seg_q       <= CNT_W'(RESET_ACTIVE);
      k_q         <= K_W'(RESET_K);
      viu_q       <= CNT_W'(RESET_VIU);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_ctr_q   <= clr_ctr_d;
      clr_reply_q <= clr_reply_d;
      phase_b_q   <= phase_b_d;
      have_prev_q <= have_prev_d;
      merged_q    <= merged_d;
      same_q      <= same_d;
      seg_q       <= seg_d;
      k_q         <= k_d;
      viu_q       <= viu_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    b_q          <= b_d;
    w_q          <= w_d;
    last_q       <= last_d;
    cur_q        <= cur_d;
    prev_q       <= prev_d;
    prev_word_q  <= prev_word_d;
    ra_q         <= ra_d;
    rb_q         <= rb_d;
    ra_size_q    <= ra_size_d;
    rb_size_q    <= rb_size_d;
    ra_imax_q    <= ra_imax_d;
    rb_imax_q    <= rb_imax_d;
    ok_a_q       <= ok_a_d;
    out_merged_q <= out_merged_d;
    out_same_q   <= out_same_d;
    out_count_q  <= out_count_d;
    out_last_q   <= out_last_d;
  end

  // forest memory
  gsm_ram #(
    .WIDTH (WORD_W),
    .DEPTH (VERTICES)
  ) u_forest (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // shared multiplier for both limit tests
  gsm_limit_test u_limit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (lim_req),
    .k_i    (k_q),
    .rsp_o  (lim_rsp)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {(M_TDATA_W - 2 - CNT_W)'(0), out_count_q, out_same_q, out_merged_q};

endmodule

// ===== rtl/gsm_port_checker.sv =====
// port level checks of the graph segment merge core, bound to the top level
// depends on gsm_pkg and graph_segment_merge_core_assert.svh
`timescale 1ns / 1ps
`include "graph_segment_merge_core_assert.svh"

module gsm_port_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [gsm_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input logic                          m_axis_tlast
);
  import gsm_pkg::*;

  // a stalled result keeps its payload
  `GSM_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "result changed while stalled")

  // a join and a shared root exclude each other
  `GSM_ASSERT_SAME(a_flags_excl, m_axis_tvalid, !(m_axis_tdata[0] && m_axis_tdata[1]), "merged and same_segment both set")

  // one item at a time: busy right after a transfer in
  `GSM_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken twice in a row")

  // clearing pass holds off input right after reset
  `GSM_ASSERT_SAME(a_clear_after_reset, !$past(rst_ni), !s_axis_tready, "input ready during clearing pass")

endmodule

bind graph_segment_merge_core gsm_port_checker u_port_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
